// ----- src/boot_trace_loop_counter_assert.svh -----
// Assertion macros shared by the boot trace loop counter RTL.
// No dependencies; each macro has an empty form when ASSERT_OFF is set.
`ifndef BOOT_TRACE_LOOP_COUNTER_ASSERT_SVH
`define BOOT_TRACE_LOOP_COUNTER_ASSERT_SVH

`ifndef ASSERT_OFF
// Plain condition checked at every clock edge outside reset.
`define BTLC_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("btlc assertion failed");
// Same-cycle implication.
`define BTLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btlc implication failed");
// Next-cycle implication.
`define BTLC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btlc next-cycle implication failed");
`else
`define BTLC_ASSERT(lbl, clk, rst_n, cond)
`define BTLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BTLC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/btlc_pkg.sv -----
// Types and constants for the boot trace loop counter.
// No dependencies; imported by all btlc modules.
package btlc_pkg;

    localparam int POS_W      = 11;   // word positions 0..2047
    localparam int CNT_W      = 32;
    localparam int TAG_W      = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int DOG_BIT    = 1;    // reset reason bit in aux word

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRACE_MAGIC   = 4'd0,
        REG_TAG_MASK      = 4'd1,
        REG_TAG_MARKER    = 4'd2,
        REG_TAG_BEGIN     = 4'd3,
        REG_TAG_DONE      = 4'd4,
        REG_TAG_CARRY     = 4'd5,
        REG_TAG_CARRY_DOG = 4'd6,
        REG_RESCUE_TAGS   = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0]      trace_magic;
        logic [31:0]      tag_mask;
        logic [31:0]      tag_marker;
        logic [TAG_W-1:0] tag_begin;
        logic [TAG_W-1:0] tag_done;
        logic [TAG_W-1:0] tag_carry;
        logic [TAG_W-1:0] tag_carry_dog;
        logic [TAG_W-1:0] rescue_boot;
        logic [TAG_W-1:0] rescue_dog;
    } btlc_cfg_t;

    typedef struct packed {
        logic             trace_valid;
        logic [POS_W-1:0] next_free;
        logic [CNT_W-1:0] boot_fail_count;
        logic [CNT_W-1:0] watchdog_streak;
        logic             page_exhausted;
        logic             scan_ended;
    } btlc_result_t;

endpackage

// ----- src/btlc_cfg.sv -----
// Configuration register file for the boot trace loop counter.
// Depends on btlc_pkg.
module btlc_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [btlc_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [btlc_pkg::CFG_DATA_W-1:0]    wr_data,
    output btlc_pkg::btlc_cfg_t                cfg
);
    import btlc_pkg::*;

    btlc_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trace_magic   <= '0;
            cfg_reg.tag_mask      <= 32'hFFFF_FF00;
            cfg_reg.tag_marker    <= '0;
            cfg_reg.tag_begin     <= 8'd1;
            cfg_reg.tag_done      <= 8'd2;
            cfg_reg.tag_carry     <= 8'd3;
            cfg_reg.tag_carry_dog <= 8'd4;
            cfg_reg.rescue_boot   <= '0;
            cfg_reg.rescue_dog    <= '0;
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_TRACE_MAGIC:   cfg_reg.trace_magic   <= wr_data;
                REG_TAG_MASK:      cfg_reg.tag_mask      <= wr_data;
                REG_TAG_MARKER:    cfg_reg.tag_marker    <= wr_data;
                REG_TAG_BEGIN:     cfg_reg.tag_begin     <= wr_data[TAG_W-1:0];
                REG_TAG_DONE:      cfg_reg.tag_done      <= wr_data[TAG_W-1:0];
                REG_TAG_CARRY:     cfg_reg.tag_carry     <= wr_data[TAG_W-1:0];
                REG_TAG_CARRY_DOG: cfg_reg.tag_carry_dog <= wr_data[TAG_W-1:0];
                REG_RESCUE_TAGS:
                begin
                    cfg_reg.rescue_boot <= wr_data[TAG_W-1:0];
                    cfg_reg.rescue_dog  <= wr_data[2*TAG_W-1:TAG_W];
                end
                default: ;   // unmapped index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/btlc_core.sv -----
// Scan state and per-word update logic of the boot trace loop counter.
// Depends on btlc_pkg and boot_trace_loop_counter_assert.svh.
`include "boot_trace_loop_counter_assert.svh"
module btlc_core #(
    parameter int PAGE_WORDS    = 1024,
    parameter int RESERVE_WORDS = 128
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [31:0]                    word,
    input  logic                           first,
    input  btlc_pkg::btlc_cfg_t            cfg,
    output btlc_pkg::btlc_result_t         result
);
    import btlc_pkg::*;

    localparam logic [POS_W-1:0] PAGE_LIM = POS_W'(PAGE_WORDS);
    localparam logic [POS_W:0]   RES_EXT  = (POS_W+1)'(RESERVE_WORDS);
    localparam logic [POS_W:0]   PAGE_EXT = (POS_W+1)'(PAGE_WORDS);

    logic [POS_W-1:0] pos_reg,     pos_next;
    logic [POS_W-1:0] nidx_reg,    nidx_next;
    logic [TAG_W-1:0] pend_reg,    pend_next;
    logic             valid_reg,   valid_next;
    logic             stop_reg,    stop_next;
    logic [CNT_W-1:0] failed_reg,  failed_next;
    logic [CNT_W-1:0] dog_reg,     dog_next;

    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] pos_sat;
    logic             tag_ok;
    logic [POS_W:0]   exh_sum;

    assign pos_inc = pos_reg + POS_W'(1);
    assign pos_sat = (pos_reg < PAGE_LIM) ? pos_inc : pos_reg;
    assign tag_ok  = ((word & cfg.tag_mask) == cfg.tag_marker) && (pos_inc < PAGE_LIM);

    always_comb
    begin
        pos_next    = pos_reg;
        nidx_next   = nidx_reg;
        pend_next   = pend_reg;
        valid_next  = valid_reg;
        stop_next   = stop_reg;
        failed_next = failed_reg;
        dog_next    = dog_reg;
        if (first)
        begin
            nidx_next   = POS_W'(1);
            failed_next = '0;
            dog_next    = '0;
            pend_next   = '0;
            valid_next  = (word == cfg.trace_magic);
            stop_next   = (word != cfg.trace_magic);
            pos_next    = POS_W'(1);
        end
        else if (stop_reg)
        begin
            pos_next = pos_sat;
        end
        else if (pos_reg[0])
        begin
            // tag word
            if (tag_ok)
            begin
                pend_next = word[TAG_W-1:0];
                pos_next  = pos_inc;
            end
            else
            begin
                stop_next = 1'b1;
                pos_next  = pos_sat;
            end
        end
        else
        begin
            // aux word: apply pending tag, first matching code wins
            if (pend_reg == cfg.tag_carry)
                failed_next = word;
            else if (pend_reg == cfg.tag_carry_dog)
                dog_next = word;
            else if (pend_reg == cfg.tag_begin)
            begin
                failed_next = failed_reg + CNT_W'(1);
                dog_next    = word[DOG_BIT] ? dog_reg + CNT_W'(1) : '0;
            end
            else if (pend_reg == cfg.tag_done)
                failed_next = '0;
            else if (pend_reg == cfg.rescue_boot || pend_reg == cfg.rescue_dog)
            begin
                failed_next = '0;
                dog_next    = '0;
            end
            nidx_next = pos_inc;
            pos_next  = pos_inc;
            if ((pos_inc + POS_W'(1)) >= PAGE_LIM)
                stop_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            nidx_reg   <= POS_W'(1);
            pend_reg   <= '0;
            valid_reg  <= 1'b0;
            stop_reg   <= 1'b1;
            failed_reg <= '0;
            dog_reg    <= '0;
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            nidx_reg   <= nidx_next;
            pend_reg   <= pend_next;
            valid_reg  <= valid_next;
            stop_reg   <= stop_next;
            failed_reg <= failed_next;
            dog_reg    <= dog_next;
        end
    end

    assign exh_sum = {1'b0, nidx_next} + RES_EXT;

    always_comb
    begin
        result.trace_valid     = valid_next;
        result.next_free       = nidx_next;
        result.boot_fail_count = failed_next;
        result.watchdog_streak = dog_next;
        result.page_exhausted  = (exh_sum >= PAGE_EXT);
        result.scan_ended      = stop_next;
    end

    // an active scan implies the page header checked out
    `BTLC_ASSERT_IMP(a_run_needs_valid, clk, rst_n, !stop_reg, valid_reg)
    // next free index always sits right after an aux word, so it is odd
    `BTLC_ASSERT(a_nidx_odd, clk, rst_n, nidx_reg[0])
    // scan position never runs past the page
    `BTLC_ASSERT(a_pos_in_page, clk, rst_n, pos_reg <= PAGE_LIM)

endmodule

// ----- src/boot_trace_loop_counter.sv -----
// Boot trace loop counter: input register, scan core, result register.
// Depends on btlc_pkg, btlc_cfg, btlc_core.
//
// Usage:
//   Trace page words arrive on the word channel (word_valid/word_ready,
//   page_word, first_word). first_word marks page word 0 and restarts the
//   scan; later words follow in page order. For every word taken, exactly
//   one result word leaves on the result channel (result_valid /
//   result_ready) carrying trace_valid, next_free, boot_fail_count,
//   watchdog_streak, page_exhausted and scan_ended after that page word.
//   An accepted word passes through the input register and then the result
//   register, where result_valid rises; throughput is one word per cycle while
//   the receiver keeps up, set by the scan update between the two registers.
//   When the receiver stalls, the result register holds; the input register
//   can still take one more word, and word_ready falls only once both are
//   full. A stall releases in the cycle result_ready returns, with no bubble.
//   Configuration writes use cfg_valid/cfg_ready (always ready) with
//   cfg_index and cfg_data; write only while no words are in flight.
//   Reset clears the pipeline, loads the register defaults and leaves the
//   scan stopped, so words before the first page word 0 report reset values.
module boot_trace_loop_counter #(
    parameter int PAGE_WORDS    = 1024,
    parameter int RESERVE_WORDS = 128
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               word_valid,
    output logic                               word_ready,
    input  logic [31:0]                        page_word,
    input  logic                               first_word,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic                               trace_valid,
    output logic [btlc_pkg::POS_W-1:0]         next_free,
    output logic [btlc_pkg::CNT_W-1:0]         boot_fail_count,
    output logic [btlc_pkg::CNT_W-1:0]         watchdog_streak,
    output logic                               page_exhausted,
    output logic                               scan_ended,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [btlc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [btlc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import btlc_pkg::*;

    btlc_cfg_t    cfg;
    btlc_result_t core_res;
    btlc_result_t res_reg;

    logic        in_vld_reg;
    logic [31:0] word_reg;
    logic        first_reg;
    logic        out_vld_reg;
    logic        advance;

    // config registers; always ready
    assign cfg_ready = 1'b1;

    btlc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // word in the input register moves into the result register when that
    // one is empty or being drained this cycle
    assign advance    = in_vld_reg && (!out_vld_reg || result_ready);
    assign word_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (word_ready)
            in_vld_reg <= word_valid;
    end

    always_ff @(posedge clk)
    begin
        if (word_valid && word_ready)
        begin
            word_reg  <= page_word;
            first_reg <= first_word;
        end
    end

    btlc_core #(
        .PAGE_WORDS    (PAGE_WORDS),
        .RESERVE_WORDS (RESERVE_WORDS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .word   (word_reg),
        .first  (first_reg),
        .cfg    (cfg),
        .result (core_res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (result_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= core_res;
    end

    assign result_valid    = out_vld_reg;
    assign trace_valid     = res_reg.trace_valid;
    assign next_free       = res_reg.next_free;
    assign boot_fail_count = res_reg.boot_fail_count;
    assign watchdog_streak = res_reg.watchdog_streak;
    assign page_exhausted  = res_reg.page_exhausted;
    assign scan_ended      = res_reg.scan_ended;

endmodule
